// File: rtl/core/ohm_e24_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ohm_e24_pkg: shared constants, tables and types
// Decade tables, the E24 series and the back-end sequencer states.
// ----------------------------------------------------------------------------
package ohm_e24_pkg;

  localparam int unsigned AdcBitsDef   = 12;
  localparam int unsigned ExpW         = 3;
  localparam int unsigned ExpMax       = 6;
  localparam int unsigned ExpReset     = 3;
  localparam int unsigned Pow10W       = 20;
  localparam int unsigned R10W         = 25;
  localparam int unsigned MantW        = 7;
  localparam int unsigned MeasW        = 32;
  localparam int unsigned ErrW         = 10;
  localparam int unsigned SeriesSteps  = 24;
  localparam int unsigned IdxW         = 5;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned MantNextDec  = 100;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RATIO,
    BK_PICK,
    BK_SCALE,
    BK_ERR,
    BK_WAIT
  } back_state_e;

  // E24 mantissa; index past the series gives the next decade
  function automatic logic [MantW-1:0] e24_value(input logic [IdxW-1:0] idx);
    logic [MantW-1:0] v;
    case (idx)
      5'd0:  v = 7'd10;
      5'd1:  v = 7'd11;
      5'd2:  v = 7'd12;
      5'd3:  v = 7'd13;
      5'd4:  v = 7'd15;
      5'd5:  v = 7'd16;
      5'd6:  v = 7'd18;
      5'd7:  v = 7'd20;
      5'd8:  v = 7'd22;
      5'd9:  v = 7'd24;
      5'd10: v = 7'd27;
      5'd11: v = 7'd30;
      5'd12: v = 7'd33;
      5'd13: v = 7'd36;
      5'd14: v = 7'd39;
      5'd15: v = 7'd43;
      5'd16: v = 7'd47;
      5'd17: v = 7'd51;
      5'd18: v = 7'd56;
      5'd19: v = 7'd62;
      5'd20: v = 7'd68;
      5'd21: v = 7'd75;
      5'd22: v = 7'd82;
      5'd23: v = 7'd91;
      default: v = 7'd100;
    endcase
    return v;
  endfunction

  // Decade in ohms for a saturated exponent
  function automatic logic [Pow10W-1:0] pow10(input logic [ExpW-1:0] e);
    logic [Pow10W-1:0] v;
    case (e)
      3'd0: v = 20'd1;
      3'd1: v = 20'd10;
      3'd2: v = 20'd100;
      3'd3: v = 20'd1000;
      3'd4: v = 20'd10000;
      3'd5: v = 20'd100000;
      default: v = 20'd1000000;
    endcase
    return v;
  endfunction

  // Ten times the known resistor, never below 330
  function automatic logic [R10W-1:0] r10(input logic [ExpW-1:0] e);
    logic [R10W-1:0] v;
    case (e)
      3'd0: v = 25'd330;
      3'd1: v = 25'd330;
      3'd2: v = 25'd3300;
      3'd3: v = 25'd33000;
      3'd4: v = 25'd330000;
      3'd5: v = 25'd3300000;
      default: v = 25'd33000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/ohm_e24_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ohm_e24_div: restoring divider, one quotient bit per cycle
// Quotient must fit in QW bits; result holds once busy drops.
// ----------------------------------------------------------------------------
module ohm_e24_div #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 20,
  parameter int unsigned QW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               busy_o,
  output logic [QW-1:0]      quo_o,
  output logic               rem_zero_o
);

  localparam int unsigned CW   = (NW > DW + QW) ? NW : DW + QW;
  localparam int unsigned CntW = $clog2(QW + 1);

  logic [CW-1:0]   rem_q, dsh_q, rem_sub;
  logic [QW-1:0]   quo_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, ge;

  // Trial subtract against the shifted divisor
  always_comb begin
    ge      = rem_q >= dsh_q;
    rem_sub = rem_q - dsh_q;
  end

  // Control: load on start, count down one bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(QW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: remainder, divisor and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= CW'(num_i);
      dsh_q <= CW'(den_i) << (QW - 1);
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_sub;
      end
      quo_q <= {quo_q[QW-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign busy_o     = busy_q;
  assign quo_o      = quo_q;
  assign rem_zero_o = (rem_q == '0);

endmodule
`default_nettype wire

// File: rtl/core/ohm_e24_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ohm_e24_queue: short FIFO between front and back end
// Registered entries, head word shown combinationally.
// ----------------------------------------------------------------------------
module ohm_e24_queue #(
  parameter int unsigned W = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] wdata_i,
  input  wire logic         pop_i,
  output logic [W-1:0]      rdata_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned Depth = ohm_e24_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);

  logic [W-1:0]    mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW + 1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (PtrW + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (PtrW + 1)'(1);
      end
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/ohm_e24_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ohm_e24_front: decade register and divider scaling
// Holds the decade exponent and turns each code into numerator and divisors.
// ----------------------------------------------------------------------------
module ohm_e24_front #(
  parameter int unsigned ADC_BITS = ohm_e24_pkg::AdcBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ohm_e24_pkg::ExpW-1:0]    cfg_decade_exponent_i,
  input  wire logic                            accept_i,
  input  wire logic [ADC_BITS-1:0]             adc_code_i,
  output logic                                 push_o,
  output logic [ADC_BITS+25-1:0]               num_o,
  output logic [ADC_BITS+21-1:0]               dd_o,
  output logic [ADC_BITS:0]                    den_o
);

  localparam int unsigned ExpW  = ohm_e24_pkg::ExpW;
  localparam int unsigned NumW  = ADC_BITS + 25;
  localparam int unsigned DdW   = ADC_BITS + 21;
  localparam int unsigned DenW  = ADC_BITS + 1;

  logic [ExpW-1:0] exp_q, exp_sat;

  // Hold the decade exponent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= ExpW'(ohm_e24_pkg::ExpReset);
    end else if (cfg_we_i) begin
      exp_q <= cfg_decade_exponent_i;
    end
  end

  // Saturate the exponent, form code*R10 and den*decade
  always_comb begin
    exp_sat = (exp_q > ExpW'(ohm_e24_pkg::ExpMax)) ? ExpW'(ohm_e24_pkg::ExpMax) : exp_q;
    den_o   = (DenW'(1) << ADC_BITS) - DenW'(adc_code_i);
    num_o   = NumW'(adc_code_i) * NumW'(ohm_e24_pkg::r10(exp_sat));
    dd_o    = DdW'(den_o) * DdW'(ohm_e24_pkg::pow10(exp_sat));
  end

  assign push_o = accept_i;

endmodule
`default_nettype wire

// File: rtl/core/ohm_e24_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ohm_e24_back: range check, E24 pick and error computation
// Sequencer driving three dividers; emits one result word per item.
// ----------------------------------------------------------------------------
module ohm_e24_back #(
  parameter int unsigned ADC_BITS = ohm_e24_pkg::AdcBitsDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                empty_i,
  input  wire logic [ADC_BITS+25-1:0]              num_i,
  input  wire logic [ADC_BITS+21-1:0]              dd_i,
  input  wire logic [ADC_BITS:0]                   den_i,
  output logic                                     pop_o,
  output logic                                     result_valid_o,
  output logic                                     in_range_o,
  output logic [ohm_e24_pkg::MeasW-1:0]            measured_q8_o,
  output logic [ohm_e24_pkg::MantW-1:0]            standard_mantissa_o,
  output logic signed [ohm_e24_pkg::ErrW-1:0]      error_centipercent_o
);

  localparam int unsigned NumW   = ADC_BITS + 25;
  localparam int unsigned DdW    = ADC_BITS + 21;
  localparam int unsigned DenW   = ADC_BITS + 1;
  localparam int unsigned Den10W = ADC_BITS + 5;
  localparam int unsigned SddW   = DdW + 7;
  localparam int unsigned MagnW  = SddW + 14;
  localparam int unsigned MantW  = ohm_e24_pkg::MantW;
  localparam int unsigned MeasW  = ohm_e24_pkg::MeasW;
  localparam int unsigned ErrW   = ohm_e24_pkg::ErrW;
  localparam int unsigned IdxW   = ohm_e24_pkg::IdxW;
  localparam int unsigned TW     = 8;

  ohm_e24_pkg::back_state_e state_q, state_d;

  logic [NumW-1:0]  num_q;
  logic [DdW-1:0]   dd_q;
  logic [MantW-1:0] s_q;
  logic [SddW-1:0]  sdd_q;
  logic [MagnW-1:0] magn_q;
  logic             neg_q;

  logic             ld_item, ld_s, ld_sdd, ld_mag, start_e, emit_ok, emit_zero;
  logic             in_rng;
  logic [SddW-1:0]  num_ext, ten_dd, hun_dd, mag;
  logic [IdxW-1:0]  k;
  logic [MantW-1:0] lo, hi, s_sel, half_t;
  logic [TW-1:0]    lohi;

  logic             m_busy, t_busy, e_busy, t_rz, e_rz, m_rz;
  logic [MeasW-1:0] m_quo;
  logic [TW-1:0]    t_quo;
  logic [ErrW-1:0]  e_quo;

  // Measured value: num*256 / (10*den)
  ohm_e24_div #(.NW(NumW + 8), .DW(Den10W), .QW(MeasW)) u_div_m (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ld_item),
    .num_i      ({num_i, 8'd0}),
    .den_i      (Den10W'(den_i) * Den10W'(10)),
    .busy_o     (m_busy),
    .quo_o      (m_quo),
    .rem_zero_o (m_rz)
  );

  // Twice the mantissa: 2*num / dd
  ohm_e24_div #(.NW(NumW + 1), .DW(DdW), .QW(TW)) u_div_t (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ld_item),
    .num_i      ({num_i, 1'b0}),
    .den_i      (dd_i),
    .busy_o     (t_busy),
    .quo_o      (t_quo),
    .rem_zero_o (t_rz)
  );

  // Error magnitude: |diff|*10000 / (s*dd)
  ohm_e24_div #(.NW(MagnW), .DW(SddW), .QW(ErrW)) u_div_e (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_e),
    .num_i      (magn_q),
    .den_i      (sdd_q),
    .busy_o     (e_busy),
    .quo_o      (e_quo),
    .rem_zero_o (e_rz)
  );

  // Range check, series search and rounding choice
  always_comb begin
    num_ext = SddW'(num_q);
    ten_dd  = SddW'(dd_q) * SddW'(10);
    hun_dd  = SddW'(dd_q) * SddW'(100);
    in_rng  = (num_ext >= ten_dd) && (num_ext < hun_dd);
    half_t  = MantW'(t_quo >> 1);
    k       = '0;
    for (int i = 0; i < ohm_e24_pkg::SeriesSteps; i++) begin
      if (ohm_e24_pkg::e24_value(IdxW'(i)) <= half_t) begin
        k = IdxW'(i);
      end
    end
    lo    = ohm_e24_pkg::e24_value(k);
    hi    = ohm_e24_pkg::e24_value(k + IdxW'(1));
    lohi  = TW'(lo) + TW'(hi);
    s_sel = ((t_quo > lohi) || ((t_quo == lohi) && !t_rz)) ? hi : lo;
    mag   = (num_ext < sdd_q) ? (sdd_q - num_ext) : (num_ext - sdd_q);
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ohm_e24_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and step controls
  always_comb begin
    state_d   = state_q;
    ld_item   = 1'b0;
    ld_s      = 1'b0;
    ld_sdd    = 1'b0;
    ld_mag    = 1'b0;
    start_e   = 1'b0;
    emit_ok   = 1'b0;
    emit_zero = 1'b0;
    case (state_q)
      ohm_e24_pkg::BK_IDLE: begin
        if (!empty_i) begin
          ld_item = 1'b1;
          state_d = ohm_e24_pkg::BK_RATIO;
        end
      end
      ohm_e24_pkg::BK_RATIO: begin
        if (!in_rng) begin
          emit_zero = 1'b1;
          state_d   = ohm_e24_pkg::BK_IDLE;
        end else if (!t_busy) begin
          ld_s    = 1'b1;
          state_d = ohm_e24_pkg::BK_PICK;
        end
      end
      ohm_e24_pkg::BK_PICK: begin
        ld_sdd  = 1'b1;
        state_d = ohm_e24_pkg::BK_SCALE;
      end
      ohm_e24_pkg::BK_SCALE: begin
        ld_mag  = 1'b1;
        state_d = ohm_e24_pkg::BK_ERR;
      end
      ohm_e24_pkg::BK_ERR: begin
        start_e = 1'b1;
        state_d = ohm_e24_pkg::BK_WAIT;
      end
      ohm_e24_pkg::BK_WAIT: begin
        if (!e_busy && !m_busy) begin
          emit_ok = 1'b1;
          state_d = ohm_e24_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = ohm_e24_pkg::BK_IDLE;
      end
    endcase
  end

  assign pop_o = ld_item;

  // Working registers
  always_ff @(posedge clk_i) begin
    if (ld_item) begin
      num_q <= num_i;
      dd_q  <= dd_i;
    end
    if (ld_s) begin
      s_q <= s_sel;
    end
    if (ld_sdd) begin
      sdd_q <= SddW'(s_q) * SddW'(dd_q);
    end
    if (ld_mag) begin
      neg_q  <= num_ext < sdd_q;
      magn_q <= MagnW'(mag) * MagnW'(14'd10000);
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= emit_ok || emit_zero;
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (emit_zero) begin
      in_range_o           <= 1'b0;
      measured_q8_o        <= '0;
      standard_mantissa_o  <= '0;
      error_centipercent_o <= '0;
    end else if (emit_ok) begin
      in_range_o           <= 1'b1;
      measured_q8_o        <= m_quo;
      standard_mantissa_o  <= s_q;
      error_centipercent_o <= neg_q ? -$signed(e_quo) : $signed(e_quo);
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/ohmmeter_e24_nearest_value_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ohmmeter_e24_nearest_value_unit: divider ohmmeter with E24 nearest value
//
// Pulse start with an ADC code while busy is low; the word is taken at that
// edge. The front scales the code by the selected decade (known resistor is
// 3.3 decades, 33 ohms minimum) and pushes it into a two-entry queue; busy
// is high only while that queue is full.
// The back end checks the range, picks the nearest E24 value (ties go low)
// and forms the signed error in hundredths of a percent. Each result shows
// for exactly one cycle with result_valid_o high; it cannot be held off.
// With the back end idle, an out-of-range code is answered from the ratio
// state without waiting for any divider; for an in-range code the result
// waits on the 32-step bit-serial divider for the measured value, which
// runs beside the mantissa and error dividers. The back end handles one
// item at a time; further codes wait in the queue until it returns to idle.
// Write the decade exponent (cfg_we_i) only while idle. Reset empties
// the queue, returns the sequencer to idle and sets the 1 kOhm decade.
// ----------------------------------------------------------------------------
module ohmmeter_e24_nearest_value_unit #(
  parameter int unsigned ADC_BITS = ohm_e24_pkg::AdcBitsDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [ohm_e24_pkg::ExpW-1:0]        cfg_decade_exponent_i,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [ADC_BITS-1:0]                 adc_code_i,
  output logic                                     result_valid_o,
  output logic                                     in_range_o,
  output logic [ohm_e24_pkg::MeasW-1:0]            measured_q8_o,
  output logic [ohm_e24_pkg::MantW-1:0]            standard_mantissa_o,
  output logic signed [ohm_e24_pkg::ErrW-1:0]      error_centipercent_o
);

  localparam int unsigned NumW  = ADC_BITS + 25;
  localparam int unsigned DdW   = ADC_BITS + 21;
  localparam int unsigned DenW  = ADC_BITS + 1;
  localparam int unsigned WordW = NumW + DdW + DenW;

  logic              push, pop, full, empty;
  logic [NumW-1:0]   f_num, b_num;
  logic [DdW-1:0]    f_dd, b_dd;
  logic [DenW-1:0]   f_den, b_den;
  logic [WordW-1:0]  head;

  assign busy = full;

  ohm_e24_front #(.ADC_BITS(ADC_BITS)) u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_decade_exponent_i (cfg_decade_exponent_i),
    .accept_i              (start && !full),
    .adc_code_i            (adc_code_i),
    .push_o                (push),
    .num_o                 (f_num),
    .dd_o                  (f_dd),
    .den_o                 (f_den)
  );

  ohm_e24_queue #(.W(WordW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_num, f_dd, f_den}),
    .pop_i   (pop),
    .rdata_o (head),
    .full_o  (full),
    .empty_o (empty)
  );

  assign {b_num, b_dd, b_den} = head;

  ohm_e24_back #(.ADC_BITS(ADC_BITS)) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .empty_i              (empty),
    .num_i                (b_num),
    .dd_i                 (b_dd),
    .den_i                (b_den),
    .pop_o                (pop),
    .result_valid_o       (result_valid_o),
    .in_range_o           (in_range_o),
    .measured_q8_o        (measured_q8_o),
    .standard_mantissa_o  (standard_mantissa_o),
    .error_centipercent_o (error_centipercent_o)
  );

endmodule
`default_nettype wire

// File: dv/ohm_e24_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohm_e24_checker: result predictor and scoreboard
// Watches accepted ADC words and configuration writes, computes the expected
// reading with exact integer arithmetic, and compares every result word.
// ----------------------------------------------------------------------------
module ohm_e24_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ohm_e24_pkg::ExpW-1:0]        cfg_decade_exponent_i,
  input  logic                                start,
  input  logic                                busy,
  input  logic [11:0]                         adc_code_i,
  input  logic                                result_valid_o,
  input  logic                                in_range_o,
  input  logic [ohm_e24_pkg::MeasW-1:0]       measured_q8_o,
  input  logic [ohm_e24_pkg::MantW-1:0]       standard_mantissa_o,
  input  logic signed [ohm_e24_pkg::ErrW-1:0] error_centipercent_o,
  output int                                  fail_count,
  output int                                  pending_count
);

  localparam int unsigned ExpW        = ohm_e24_pkg::ExpW;
  localparam int unsigned MeasW       = ohm_e24_pkg::MeasW;
  localparam int unsigned MantW       = ohm_e24_pkg::MantW;
  localparam int unsigned ErrW        = ohm_e24_pkg::ErrW;
  localparam int unsigned SeriesSteps = ohm_e24_pkg::SeriesSteps;

  typedef struct packed {
    logic              in_range;
    logic [MeasW-1:0]  measured;
    logic [MantW-1:0]  mantissa;
    logic [ErrW-1:0]   err;
  } reading_t;

  localparam byte unsigned SERIES[SeriesSteps] = '{10, 11, 12, 13, 15, 16, 18, 20,
    22, 24, 27, 30, 33, 36, 39, 43, 47, 51, 56, 62, 68, 75, 82, 91};

  logic [ExpW-1:0] decade_exp;
  reading_t        expected_readings[$];

  // Predict one reading from the code and the current decade
  function automatic reading_t predict_reading(logic [11:0] code, logic [ExpW-1:0] ex);
    reading_t r;
    longint   e, dec, kr10, num, dd, lo, hi, s, diff, errv;
    int       k;
    r    = '0;
    e    = (ex > ohm_e24_pkg::ExpMax) ? ohm_e24_pkg::ExpMax : ex;
    dec  = 1;
    for (int i = 0; i < e; i++) dec = dec * 10;
    kr10 = (e == 0) ? 330 : 33 * dec;
    num  = longint'(code) * kr10;
    dd   = (4096 - longint'(code)) * dec;
    if (num < 10 * dd || num >= 100 * dd) return r;
    k = 0;
    for (int i = 0; i < SeriesSteps; i++)
      if (SERIES[i] * dd <= num) k = i;
    lo   = SERIES[k];
    hi   = (k + 1 < SeriesSteps) ? SERIES[k + 1] : ohm_e24_pkg::MantNextDec;
    s    = (2 * num > (lo + hi) * dd) ? hi : lo;
    diff = num - s * dd;
    errv = (diff * 10000) / (s * dd);
    r.in_range = 1'b1;
    r.measured = MeasW'((num * 256) / (10 * (4096 - longint'(code))));
    r.mantissa = MantW'(s);
    r.err      = ErrW'(errv);
    return r;
  endfunction

  // Track the register, queue predictions, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t exp_r;
    if (!rst_ni) begin
      decade_exp    = ExpW'(ohm_e24_pkg::ExpReset);
      fail_count    = 0;
      expected_readings.delete();
      pending_count = 0;
    end else begin
      if (start && !busy)
        expected_readings.push_back(predict_reading(adc_code_i, decade_exp));
      if (cfg_we_i) decade_exp = cfg_decade_exponent_i;
      if (result_valid_o) begin
        if (expected_readings.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word at %0t", $realtime);
        end else begin
          exp_r = expected_readings.pop_front();
          if (exp_r.in_range !== in_range_o || exp_r.measured !== measured_q8_o ||
              exp_r.mantissa !== standard_mantissa_o || exp_r.err !== error_centipercent_o) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp %0b %0d %0d %0d got %0b %0d %0d %0d",
                       exp_r.in_range, exp_r.measured, exp_r.mantissa,
                       $signed(exp_r.err), in_range_o, measured_q8_o,
                       standard_mantissa_o, error_centipercent_o);
          end
        end
      end
      pending_count = expected_readings.size();
    end
  end
endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: E24 ohmmeter stimulus and verdict
// Drives directed and random ADC words over every decade setting with random
// gaps; the checker predicts and compares each result word.
// ----------------------------------------------------------------------------
module testbench;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                cfg_we_i = 1'b0;
  logic [ohm_e24_pkg::ExpW-1:0]        cfg_decade_exponent_i = '0;
  logic                                start = 1'b0;
  logic                                busy;
  logic [11:0]                         adc_code_i = '0;
  logic                                result_valid_o;
  logic                                in_range_o;
  logic [ohm_e24_pkg::MeasW-1:0]       measured_q8_o;
  logic [ohm_e24_pkg::MantW-1:0]       standard_mantissa_o;
  logic signed [ohm_e24_pkg::ErrW-1:0] error_centipercent_o;
  int                                  fail_count;
  int                                  pending_count;
  int                                  idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ohmmeter_e24_nearest_value_unit dut (.*);

  ohm_e24_checker checker_i (.*);

  // Watchdog on cycles without any accepted word or result
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Send one word after a random gap; hold start until accepted
  task automatic send_code(logic [11:0] code);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    adc_code_i <= code;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start and wait until every expected word has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  // Let the block drain before touching the register
  task automatic drain_and_set(logic [ohm_e24_pkg::ExpW-1:0] ex);
    wait_drained();
    repeat (50) @(posedge clk_i);
    cfg_we_i              <= 1'b1;
    cfg_decade_exponent_i <= ex;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Code near the in-range window of decades 1 and up (about 1/1.33 to 1/4.3)
  function automatic logic [11:0] draw_code();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 12'($urandom);
    if (sel == 1) return 12'($urandom_range(4000, 4095));
    return 12'($urandom_range(900, 3100));
  endfunction

  localparam int unsigned DIRECTED[20] = '{0, 1, 4095, 4094, 2048, 1024, 3072, 953,
    954, 955, 3073, 3074, 3075, 2731, 1171, 1560, 2200, 2520, 2840, 1365};

  initial begin
    logic [ohm_e24_pkg::ExpW-1:0] ex;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed edges at reset decade, then at the extremes
    foreach (DIRECTED[i]) send_code(12'(DIRECTED[i]));
    drain_and_set(3'd0);
    foreach (DIRECTED[i]) send_code(12'(DIRECTED[i]));
    drain_and_set(3'd7);
    foreach (DIRECTED[i]) send_code(12'(DIRECTED[i]));
    // Random phases through all decade settings
    for (int ph = 0; ph < 16; ph++) begin
      ex = (ph < 8) ? 3'(ph) : 3'($urandom);
      drain_and_set(ex);
      for (int n = 0; n < 112; n++) begin
        send_code(draw_code());
        if (n == 60 && ph == 2) wait_drained();
      end
    end
    wait_drained();
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
